// ===== rtl/rbsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared types and constants of the ray/box slab intersection unit: the
// fixed-point format, the ray and result words and the register indexes.
// ----------------------------------------------------------------------------
package rbsi_pkg;

	// Fixed-point format: signed, COORD_W bits, FRAC_BITS fraction bits
	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 16;
	localparam int NUM_AXES  = 3;

	// Slab distance arithmetic widths
	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = DIFF_W + COORD_W;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BOX_MIN_X = 3'd0,
		CFG_BOX_MIN_Y = 3'd1,
		CFG_BOX_MIN_Z = 3'd2,
		CFG_BOX_MAX_X = 3'd3,
		CFG_BOX_MAX_Y = 3'd4,
		CFG_BOX_MAX_Z = 3'd5
	} cfg_reg_t;

	// Input word: one ray
	typedef struct packed {
		coord_t origin_x;
		coord_t origin_y;
		coord_t origin_z;
		coord_t inv_dir_x;
		coord_t inv_dir_y;
		coord_t inv_dir_z;
	} ray_t;

	// Output word: one test result
	typedef struct packed {
		logic   hit;
		coord_t t_enter;
		coord_t t_exit;
	} result_t;

endpackage

// ===== rtl/rbsi_slab.sv =====
// ----------------------------------------------------------------------------
// rbsi_slab
// One axis of the slab test: bound minus origin, times the reciprocal
// direction, floor shift and saturate, then order the two distances.
// Three stages, free running; the valid bits live in the top level.
// ----------------------------------------------------------------------------
module rbsi_slab
	import rbsi_pkg::*;
(
	input  logic   clk,
	input  coord_t box_lo,
	input  coord_t box_hi,
	input  coord_t origin,
	input  coord_t inv_dir,
	output coord_t near_s3,
	output coord_t far_s3
);

	diff_t  d_lo_s1, d_hi_s1;
	coord_t inv_s1;
	prod_t  p_lo_s2, p_hi_s2;
	coord_t t_lo, t_hi;

	// Floor shift of the product, clamp to the coordinate range
	function automatic coord_t shift_sat(input prod_t p);
		prod_t sh;
		logic  fits;
		sh   = p >>> FRAC_BITS;
		fits = (sh[PROD_W-1:COORD_W-1] == {(PROD_W-COORD_W+1){1'b0}}) ||
		       (sh[PROD_W-1:COORD_W-1] == {(PROD_W-COORD_W+1){1'b1}});
		if (fits) begin
			return sh[COORD_W-1:0];
		end else if (sh[PROD_W-1]) begin
			return COORD_MIN;
		end else begin
			return COORD_MAX;
		end
	endfunction

	// Stage 1: distance from origin to each bound
	always_ff @(posedge clk) begin
		d_lo_s1 <= DIFF_W'(box_lo) - DIFF_W'(origin);
		d_hi_s1 <= DIFF_W'(box_hi) - DIFF_W'(origin);
		inv_s1  <= inv_dir;
	end

	// Stage 2: full-precision products
	always_ff @(posedge clk) begin
		p_lo_s2 <= PROD_W'(d_lo_s1) * PROD_W'(inv_s1);
		p_hi_s2 <= PROD_W'(d_hi_s1) * PROD_W'(inv_s1);
	end

	// Stage 3: back to Q format, order near and far
	always_comb begin
		t_lo = shift_sat(p_lo_s2);
		t_hi = shift_sat(p_hi_s2);
	end

	always_ff @(posedge clk) begin
		if (t_lo < t_hi) begin
			near_s3 <= t_lo;
			far_s3  <= t_hi;
		end else begin
			near_s3 <= t_hi;
			far_s3  <= t_lo;
		end
	end

endmodule

// ===== rtl/rbsi_merge.sv =====
// ----------------------------------------------------------------------------
// rbsi_merge
// Combine the per-axis intervals: largest entry, smallest exit, then the
// hit decision. Two stages, free running.
// ----------------------------------------------------------------------------
module rbsi_merge
	import rbsi_pkg::*;
(
	input  logic    clk,
	input  coord_t  near_s3 [NUM_AXES],
	input  coord_t  far_s3  [NUM_AXES],
	output result_t result_s5
);

	coord_t enter, leave;
	coord_t enter_s4, leave_s4;

	// Reduce the three axes
	always_comb begin
		enter = near_s3[0];
		leave = far_s3[0];
		for (int a = 1; a < NUM_AXES; a++) begin
			if (near_s3[a] > enter) begin
				enter = near_s3[a];
			end
			if (far_s3[a] < leave) begin
				leave = far_s3[a];
			end
		end
	end

	// Stage 4: hold the interval
	always_ff @(posedge clk) begin
		enter_s4 <= enter;
		leave_s4 <= leave;
	end

	// Stage 5: drop rays behind the origin or with an empty interval
	always_ff @(posedge clk) begin
		result_s5.hit     <= !(leave_s4[COORD_W-1] || (enter_s4 > leave_s4));
		result_s5.t_enter <= enter_s4;
		result_s5.t_exit  <= leave_s4;
	end

endmodule

// ===== rtl/ray_box_slab_intersection_unit.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_intersection_unit
// Ray against axis-aligned box slab test in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Write the six box bounds through cfg_we / cfg_index / cfg_data while no
//   ray is in flight; indexes 0..2 are the lower x/y/z bounds, 3..5 the upper.
//   Writes to other indexes are dropped.
//   A ray word is taken at each clock edge with start high and busy low.
//   busy never rises, so one ray may enter every cycle.
//   Each result word appears on result for one cycle with done high;
//   results keep ray order. The five pipeline stages are: subtract,
//   33x32 multiply, shift/saturate with per-axis ordering, three-axis
//   reduce, hit decision.
//   Throughput is one ray per cycle.
//   The receiver cannot stall; a result not taken in its cycle is gone.
//   Reset empties the pipeline and loads an empty box: lower bounds at the
//   largest coordinate, upper bounds at the smallest.
// ----------------------------------------------------------------------------
module ray_box_slab_intersection_unit
	import rbsi_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data,
	input  logic                 start,
	output logic                 busy,
	input  ray_t                 ray,
	output logic                 done,
	output result_t              result
);

	coord_t  box_lo_q [NUM_AXES];
	coord_t  box_hi_q [NUM_AXES];
	coord_t  origin   [NUM_AXES];
	coord_t  inv_dir  [NUM_AXES];
	coord_t  near_s3  [NUM_AXES];
	coord_t  far_s3   [NUM_AXES];
	result_t result_s5;
	logic    v_s1, v_s2, v_s3, v_s4, v_s5;
	logic    accept;

	// The pipeline never blocks
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Box registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				box_lo_q[a] <= COORD_MAX;
				box_hi_q[a] <= COORD_MIN;
			end
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_BOX_MIN_X: box_lo_q[0] <= cfg_data;
				CFG_BOX_MIN_Y: box_lo_q[1] <= cfg_data;
				CFG_BOX_MIN_Z: box_lo_q[2] <= cfg_data;
				CFG_BOX_MAX_X: box_hi_q[0] <= cfg_data;
				CFG_BOX_MAX_Y: box_hi_q[1] <= cfg_data;
				CFG_BOX_MAX_Z: box_hi_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Split the ray word per axis
	assign origin[0]  = ray.origin_x;
	assign origin[1]  = ray.origin_y;
	assign origin[2]  = ray.origin_z;
	assign inv_dir[0] = ray.inv_dir_x;
	assign inv_dir[1] = ray.inv_dir_y;
	assign inv_dir[2] = ray.inv_dir_z;

	// Per-axis slab lanes
	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		rbsi_slab u_slab (
			.clk     (clk),
			.box_lo  (box_lo_q[a]),
			.box_hi  (box_hi_q[a]),
			.origin  (origin[a]),
			.inv_dir (inv_dir[a]),
			.near_s3 (near_s3[a]),
			.far_s3  (far_s3[a])
		);
	end

	rbsi_merge u_merge (
		.clk       (clk),
		.near_s3   (near_s3),
		.far_s3    (far_s3),
		.result_s5 (result_s5)
	);

	// Advance the valid bits alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign done   = v_s5;
	assign result = result_s5;

`ifndef NO_ASSERTIONS
	// Every result word comes from a ray taken earlier
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 5))
		else $error("result word without a matching ray");

	// Hit flag agrees with the reported interval
	a_hit_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.hit == (!result.t_exit[COORD_W-1] &&
		                         (result.t_enter <= result.t_exit))))
		else $error("hit flag disagrees with interval");

	// A taken ray always yields a result word
	a_start_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##5 done)
		else $error("ray taken but no result word");
`endif

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ray/box slab intersection unit. Rays go in
// through the start/busy handshake while a scoreboard predicts each result
// word from its own copy of the box bounds. Results are matched in order
// as done strobes them. Runs a directed set, then random rays over a
// series of box settings: normal, full range, inverted, tiny and extreme.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
	import rbsi_pkg::*;

	localparam int PIPE_LAT      = 5;
	localparam int STALL_LIMIT   = 2000;
	localparam int PHASE_RAYS    = 170;
	localparam int NUM_PHASES    = 6;
	localparam int MAX_REPORTS   = 10;

	// Indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

	// Handy Q16.16 values
	localparam coord_t Q_ONE   = 32'sh0001_0000;
	localparam coord_t Q_HALF  = 32'sh0000_8000;
	localparam coord_t Q_EIGHT = 32'sh0008_0000;
	localparam coord_t Q_M1LSB = 32'shffff_ffff;

	typedef logic signed [2*COORD_W:0] wide_t;

	// ------------------------------------------------------------------
	// Box slab predictor and in-order result matcher
	// ------------------------------------------------------------------
	class slab_scoreboard;
		coord_t  box_lo [3];
		coord_t  box_hi [3];
		result_t expected_q [$];
		int      errors;

		function new();
			for (int a = 0; a < 3; a++) begin
				box_lo[a] = COORD_MAX;
				box_hi[a] = COORD_MIN;
			end
			errors = 0;
		endfunction

		// Track a register write; spare indexes are dropped
		function void set_bound(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
			case (idx)
				CFG_BOX_MIN_X: box_lo[0] = data;
				CFG_BOX_MIN_Y: box_lo[1] = data;
				CFG_BOX_MIN_Z: box_lo[2] = data;
				CFG_BOX_MAX_X: box_hi[0] = data;
				CFG_BOX_MAX_Y: box_hi[1] = data;
				CFG_BOX_MAX_Z: box_hi[2] = data;
				default: ;
			endcase
		endfunction

		// Exact product, floor shift, saturate to the coordinate range
		function coord_t slab_dist(coord_t bound, coord_t org, coord_t inv);
			wide_t d, m, q;
			d = wide_t'(bound) - wide_t'(org);
			m = d * wide_t'(inv);
			q = m >>> FRAC_BITS;
			if (q > wide_t'(COORD_MAX))
				return COORD_MAX;
			if (q < wide_t'(COORD_MIN))
				return COORD_MIN;
			return coord_t'(q);
		endfunction

		function result_t slab_result(ray_t r);
			coord_t  org [3];
			coord_t  inv [3];
			coord_t  ta, tb, near_t, far_t, enter, leave;
			result_t res;
			org[0] = r.origin_x;  org[1] = r.origin_y;  org[2] = r.origin_z;
			inv[0] = r.inv_dir_x; inv[1] = r.inv_dir_y; inv[2] = r.inv_dir_z;
			enter = '0;
			leave = '0;
			for (int a = 0; a < 3; a++) begin
				ta = slab_dist(box_lo[a], org[a], inv[a]);
				tb = slab_dist(box_hi[a], org[a], inv[a]);
				near_t = (ta < tb) ? ta : tb;
				far_t  = (ta < tb) ? tb : ta;
				if (a == 0 || near_t > enter)
					enter = near_t;
				if (a == 0 || far_t < leave)
					leave = far_t;
			end
			res.hit     = !(leave < 0 || enter > leave);
			res.t_enter = enter;
			res.t_exit  = leave;
			return res;
		endfunction

		function void note_ray(ray_t r);
			expected_q.push_back(slab_result(r));
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endfunction

		// Compare one result word with the oldest expectation
		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				flag($sformatf("result with nothing expected: hit=%0b t_enter=%h t_exit=%h",
					got.hit, got.t_enter, got.t_exit));
				return;
			end
			want = expected_q.pop_front();
			if (got.hit !== want.hit || got.t_enter !== want.t_enter
					|| got.t_exit !== want.t_exit)
				flag($sformatf("expected hit=%0b t_enter=%h t_exit=%h, got hit=%0b t_enter=%h t_exit=%h",
					want.hit, want.t_enter, want.t_exit,
					got.hit, got.t_enter, got.t_exit));
		endfunction
	endclass

	// ------------------------------------------------------------------
	// Block under test
	// ------------------------------------------------------------------
	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0]   cfg_data  = '0;
	logic                 start     = 1'b0;
	logic                 busy;
	ray_t                 ray       = '0;
	logic                 done;
	result_t              result;

	slab_scoreboard sb = new();

	ray_box_slab_intersection_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.start     (start),
		.busy      (busy),
		.ray       (ray),
		.done      (done),
		.result    (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Sample accepted words at each edge
	always @(posedge clk) begin
		if (done)
			sb.check_result(result);
		if (arst_n && start && !busy)
			sb.note_ray(ray);
	end

	// Stall watchdog: end the run when nothing moves for too long
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("ray_box_slab_intersection_unit regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic coord_t rand_edge();
		case ($urandom_range(6))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2: return '0;
			3: return 32'sd1;
			4: return Q_M1LSB;
			5: return Q_ONE;
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic coord_t rand_noise();
		return ($urandom_range(1) == 0) ? coord_t'($urandom) : rand_edge();
	endfunction

	// Value around the span of two bounds, reaching half a span beyond
	function automatic coord_t rand_near(coord_t a, coord_t b);
		longint lo, hi, span, v;
		logic [63:0] pick;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		span = hi - lo + 1;
		pick = {$urandom, $urandom};
		v = lo - span / 2 + longint'(pick % 64'(2 * span));
		if (v > longint'(COORD_MAX))
			v = COORD_MAX;
		if (v < longint'(COORD_MIN))
			v = COORD_MIN;
		return coord_t'(v);
	endfunction

	function automatic coord_t rand_inv();
		coord_t mag;
		int     r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		if (r < 16)
			return rand_edge();
		if (r < 30)
			return coord_t'($urandom);
		mag = coord_t'($urandom_range(32'h0008_0000, 1));
		return ($urandom_range(1) == 0) ? mag : -mag;
	endfunction

	// Mostly rays aimed around the current box, some pure noise
	function automatic ray_t rand_ray();
		ray_t r;
		if ($urandom_range(99) < 80) begin
			r.origin_x  = rand_near(sb.box_lo[0], sb.box_hi[0]);
			r.origin_y  = rand_near(sb.box_lo[1], sb.box_hi[1]);
			r.origin_z  = rand_near(sb.box_lo[2], sb.box_hi[2]);
			r.inv_dir_x = rand_inv();
			r.inv_dir_y = rand_inv();
			r.inv_dir_z = rand_inv();
		end else begin
			r.origin_x  = rand_noise();
			r.origin_y  = rand_noise();
			r.origin_z  = rand_noise();
			r.inv_dir_x = rand_noise();
			r.inv_dir_y = rand_noise();
			r.inv_dir_z = rand_noise();
		end
		return r;
	endfunction

	function automatic ray_t mk_ray(coord_t ox, coord_t oy, coord_t oz,
			coord_t ix, coord_t iy, coord_t iz);
		ray_t r;
		r.origin_x  = ox;
		r.origin_y  = oy;
		r.origin_z  = oz;
		r.inv_dir_x = ix;
		r.inv_dir_y = iy;
		r.inv_dir_z = iz;
		return r;
	endfunction

	// Present one ray word and hold it until taken
	task automatic send_ray(input ray_t r);
		start <= 1'b1;
		ray   <= r;
		do @(posedge clk); while (busy);
	endtask

	// Idle about one cycle in five, with junk on the ray bus
	task automatic maybe_idle(input bit no_gaps);
		if (!no_gaps) begin
			while ($urandom_range(99) < 20) begin
				start <= 1'b0;
				ray   <= {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
				@(posedge clk);
			end
		end
	endtask

	// Drop start and wait for the pipeline to empty
	task automatic drain();
		start <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 3) @(posedge clk);
	endtask

	// Load all six bounds, plus one write to a spare index
	task automatic write_box(input coord_t lo [3], input coord_t hi [3]);
		logic [CFG_IDX_W-1:0] idx [7];
		logic [COORD_W-1:0]   val [7];
		idx[0] = ($urandom_range(1) == 0) ? CFG_IDX_SPARE_LO : CFG_IDX_SPARE_HI;
		val[0] = $urandom;
		idx[1] = CFG_BOX_MIN_X; val[1] = lo[0];
		idx[2] = CFG_BOX_MIN_Y; val[2] = lo[1];
		idx[3] = CFG_BOX_MIN_Z; val[3] = lo[2];
		idx[4] = CFG_BOX_MAX_X; val[4] = hi[0];
		idx[5] = CFG_BOX_MAX_Y; val[5] = hi[1];
		idx[6] = CFG_BOX_MAX_Z; val[6] = hi[2];
		for (int i = 0; i < 7; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			sb.set_bound(idx[i], val[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		coord_t lo [3];
		coord_t hi [3];
		coord_t span;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset box: empty, tested as is
		send_ray(mk_ray('0, '0, '0, Q_ONE, Q_ONE, Q_ONE));
		send_ray(mk_ray(COORD_MAX, COORD_MIN, '0, COORD_MIN, COORD_MAX, Q_ONE));
		send_ray(mk_ray('0, '0, '0, '0, '0, '0));
		drain();

		// Box [-8, 8] on every axis
		for (int a = 0; a < 3; a++) begin
			lo[a] = -Q_EIGHT;
			hi[a] = Q_EIGHT;
		end
		write_box(lo, hi);
		send_ray(mk_ray('0, '0, '0, Q_ONE, Q_ONE, Q_ONE));
		send_ray(mk_ray('0, '0, '0, Q_ONE, '0, '0));
		send_ray(mk_ray('0, '0, '0, '0, '0, '0));
		send_ray(mk_ray(32'sh0014_0000, '0, '0, Q_ONE, Q_ONE, Q_ONE));
		send_ray(mk_ray(-32'sh0010_0000, 32'sh0010_0000, '0, Q_ONE, Q_ONE, Q_ONE));
		send_ray(mk_ray(-32'sh0010_0000, '0, '0, Q_ONE, COORD_MAX, COORD_MAX));
		send_ray(mk_ray(COORD_MAX, COORD_MIN, '0, COORD_MIN, COORD_MAX, -Q_ONE));
		send_ray(mk_ray(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
		send_ray(mk_ray(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
		send_ray(mk_ray(Q_M1LSB, Q_M1LSB, Q_M1LSB, Q_M1LSB, Q_M1LSB, Q_M1LSB));
		send_ray(mk_ray(32'sd3, -32'sd5, 32'sd1, -Q_HALF, Q_HALF, -32'sd3));
		send_ray(mk_ray(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
			32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA));
		send_ray(mk_ray(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
			32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555));
		drain();

		// Inverted x slab: bounds not reordered
		lo[0] = Q_EIGHT;
		hi[0] = -Q_EIGHT;
		write_box(lo, hi);
		send_ray(mk_ray('0, '0, '0, Q_ONE, Q_ONE, Q_ONE));
		send_ray(mk_ray(-32'sh0010_0000, '0, '0, -Q_ONE, Q_HALF, Q_ONE));
		drain();

		// Random rays over a series of box settings
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			for (int a = 0; a < 3; a++) begin
				case (ph)
					0: begin
						lo[a] = -Q_EIGHT;
						hi[a] = Q_EIGHT;
					end
					1: begin
						lo[a] = coord_t'($urandom_range(32'h0080_0000)) - 32'sh0040_0000;
						hi[a] = lo[a] + coord_t'($urandom_range(32'h0020_0000, 1));
					end
					2: begin
						lo[a] = COORD_MIN;
						hi[a] = COORD_MAX;
					end
					3: begin
						hi[a] = coord_t'($urandom_range(32'h0080_0000)) - 32'sh0040_0000;
						lo[a] = hi[a] + coord_t'($urandom_range(32'h0020_0000, 1));
					end
					4: begin
						lo[a] = rand_noise();
						hi[a] = rand_noise();
					end
					default: begin
						span  = coord_t'($urandom_range(16, 1));
						lo[a] = coord_t'($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
						hi[a] = lo[a] + span;
					end
				endcase
			end
			write_box(lo, hi);
			for (int n = 0; n < PHASE_RAYS; n++) begin
				// full-range phase runs back to back
				maybe_idle(ph == 2);
				send_ray(rand_ray());
			end
			drain();
		end

		// Wait out the tail of the pipeline
		repeat (PIPE_LAT + 5) @(posedge clk);
		if (sb.expected_q.size() != 0)
			sb.flag($sformatf("%0d results never arrived", sb.expected_q.size()));

		if (sb.errors == 0)
			$display("ray_box_slab_intersection_unit regression: pass");
		else
			$display("ray_box_slab_intersection_unit regression: fail");
		$finish;
	end

endmodule
